// File: sv/macs_pkg.sv
// ----------------------------------------------------------------------------
// Moving average crossover package
// Shared constants, codes, state encoding and the control bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package macs_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int PRICE_WIDTH_DEF = 32;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 9;
  localparam int DAYS_W    = 16;
  localparam int CONF_W    = 14;
  localparam int DIV_W     = DAYS_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 8'd1;

  localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 9'd50;
  localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 9'd200;

  localparam logic [1:0] SIG_WARMUP  = 2'd0;
  localparam logic [1:0] SIG_NOTREND = 2'd1;
  localparam logic [1:0] SIG_BUY     = 2'd2;
  localparam logic [1:0] SIG_SELL    = 2'd3;

  localparam logic [1:0] SGN_NONE = 2'd0;
  localparam logic [1:0] SGN_NEG  = 2'd1;
  localparam logic [1:0] SGN_ZERO = 2'd2;
  localparam logic [1:0] SGN_POS  = 2'd3;

  localparam logic [DAYS_W-1:0] DAYS_MAX = 16'hFFFF;

  localparam logic [CONF_W-1:0] CONF_BASE = 14'd5000;
  localparam logic [CONF_W-1:0] CONF_NUM  = 14'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LONG,
    ST_UPDATE,
    ST_MUL_L,
    ST_MUL_R,
    ST_COMPARE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_long;
    logic capture_short;
    logic update;
    logic mul_lhs;
    logic mul_rhs;
    logic compare;
    logic take_quot;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic warm;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: sv/moving_average_crossover_signal_core.sv
// ----------------------------------------------------------------------------
// Moving average crossover signal core
// Dual simple moving average crossover detector with held buy/sell signal,
// days-since counter and confidence figure.
// ----------------------------------------------------------------------------
// Usage: prices enter on the sample channel (sample_valid, sample_stall,
// price) and one result per price leaves on the result channel
// (result_valid, result_stall, signal, crossover, days_since,
// confidence_hundredths). A transaction completes when valid is high and
// stall is low. The window lengths are written through the cfg channel,
// which is always ready; a write to either window clears the history,
// sums and signal state, and must only be issued while the block is idle.
// One price is processed at a time. During warm-up the result is loaded
// into the output stage straight after the sum update. Once the long
// window is full a result also waits for the two cross products on the
// shared multiplier, the comparison and the 14-step confidence divider.
// The finished result sits in an output register, so a stalled receiver
// holds it stable; the next price is accepted meanwhile and its result
// waits until the register is taken. Reset restores windows 50 and 200,
// clears all stream state and drops any pending result.
// ----------------------------------------------------------------------------
module moving_average_crossover_signal_core #(
  parameter int MAX_WINDOW  = macs_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_WIDTH = macs_pkg::PRICE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [PRICE_WIDTH-1:0]  price,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     signal,
  output logic                           crossover,
  output logic [macs_pkg::DAYS_W-1:0]    days_since,
  output logic [macs_pkg::CONF_W-1:0]    confidence_hundredths,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [macs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [macs_pkg::CFG_W-1:0]     cfg_data
);
  import macs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  macs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  macs_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .cfg_wr                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .price                 (price),
    .result_valid          (result_valid),
    .result_stall          (result_stall),
    .signal                (signal),
    .crossover             (crossover),
    .days_since            (days_since),
    .confidence_hundredths (confidence_hundredths)
  );

endmodule

// File: sv/macs_div.sv
// ----------------------------------------------------------------------------
// Confidence divider
// Restoring divider that computes 10000 / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module macs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [macs_pkg::DIV_W-1:0]  divisor,
  output logic                        done,
  output logic [macs_pkg::CONF_W-1:0] quotient
);
  import macs_pkg::*;

  localparam int CNT_W = $clog2(CONF_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    divisor_r;
  logic [CONF_W-1:0]   qd;
  logic [DIV_W:0]      rem_sh;
  logic                qbit;
  logic [DIV_W-1:0]    rem_next;

  always_comb begin
    rem_sh   = {rem, qd[CONF_W-1]};
    qbit     = (rem_sh >= {1'b0, divisor_r});
    rem_next = qbit ? DIV_W'(rem_sh - {1'b0, divisor_r}) : DIV_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CONF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      qd        <= CONF_NUM;
      divisor_r <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      qd  <= {qd[CONF_W-2:0], qbit};
    end
  end

  assign quotient = qd;

endmodule

// File: sv/macs_ctrl.sv
// ----------------------------------------------------------------------------
// Moving average crossover controller
// Sequences the history reads, sum update, cross products, comparison,
// confidence division and result hand-off for one transaction at a time.
// ----------------------------------------------------------------------------
module macs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  macs_pkg::status_t status,
  output macs_pkg::cmd_t    cmd
);
  import macs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (sample_valid) state_next = ST_RD_LONG;
      ST_RD_LONG: state_next = ST_UPDATE;
      ST_UPDATE:  state_next = status.warm ? ST_OUTPUT : ST_MUL_L;
      ST_MUL_L:   state_next = ST_MUL_R;
      ST_MUL_R:   state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_DIVIDE;
      ST_DIVIDE:  if (status.div_done) state_next = ST_OUTPUT;
      ST_OUTPUT:  if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.accept   = sample_valid;
      end
      ST_RD_LONG: begin
        cmd.rd_long       = 1'b1;
        cmd.capture_short = 1'b1;
      end
      ST_UPDATE:  cmd.update    = 1'b1;
      ST_MUL_L:   cmd.mul_lhs   = 1'b1;
      ST_MUL_R:   cmd.mul_rhs   = 1'b1;
      ST_COMPARE: cmd.compare   = 1'b1;
      ST_DIVIDE:  cmd.take_quot = status.div_done;
      ST_OUTPUT:  cmd.load_out  = status.out_free;
      default:    cmd           = '0;
    endcase
  end

endmodule

// File: sv/macs_datapath.sv
// ----------------------------------------------------------------------------
// Moving average crossover datapath
// Holds the window registers, price history ring, running sums, shared
// multiplier, crossover state, confidence divider and the output register.
// ----------------------------------------------------------------------------
module macs_datapath #(
  parameter int MAX_WINDOW  = macs_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_WIDTH = macs_pkg::PRICE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  macs_pkg::cmd_t                 cmd,
  output macs_pkg::status_t              status,
  input  logic                           cfg_wr,
  input  logic [macs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [macs_pkg::CFG_W-1:0]     cfg_data,
  input  logic signed [PRICE_WIDTH-1:0]  price,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     signal,
  output logic                           crossover,
  output logic [macs_pkg::DAYS_W-1:0]    days_since,
  output logic [macs_pkg::CONF_W-1:0]    confidence_hundredths
);
  import macs_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int AW     = WIN_W + 1;
  localparam int CMP_W  = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int SUM_W  = PRICE_WIDTH + $clog2(MAX_WINDOW);
  localparam int PROD_W = SUM_W + WIN_W + 1;

  // Configuration and effective windows.
  logic [CFG_W-1:0] short_window;
  logic [CFG_W-1:0] long_window;
  logic [CMP_W-1:0] sw_ext;
  logic [CMP_W-1:0] lw_ext;
  logic [WIN_W-1:0] s_c;
  logic [WIN_W-1:0] l_c;
  logic [WIN_W-1:0] win_s;
  logic [WIN_W-1:0] win_l;
  logic             clear;

  // Stream state.
  logic [PRICE_WIDTH-1:0]        hist_mem [MAX_WINDOW];
  logic signed [PRICE_WIDTH-1:0] rdata;
  logic signed [PRICE_WIDTH-1:0] old_s;
  logic signed [PRICE_WIDTH-1:0] price_r;
  logic [PTR_W-1:0]              wp;
  logic [PTR_W-1:0]              wp_next;
  logic [WIN_W-1:0]              samples_seen;
  logic [WIN_W-1:0]              samples_seen_next;
  logic                          warm;
  logic signed [SUM_W-1:0]       short_sum;
  logic signed [SUM_W-1:0]       long_sum;
  logic signed [SUM_W-1:0]       drop_s;
  logic signed [SUM_W-1:0]       drop_l;
  logic signed [SUM_W-1:0]       short_sum_next;
  logic signed [SUM_W-1:0]       long_sum_next;
  logic [AW-1:0]                 sum_s;
  logic [AW-1:0]                 sum_l;
  logic [PTR_W-1:0]              addr_s;
  logic [PTR_W-1:0]              addr_l;
  logic [PTR_W-1:0]              rd_addr;

  // Comparison and signal state.
  logic signed [SUM_W-1:0]  mul_a;
  logic signed [WIN_W:0]    mul_b;
  logic signed [PROD_W-1:0] mul_out;
  logic signed [PROD_W-1:0] lhs;
  logic signed [PROD_W-1:0] rhs;
  logic [1:0]               prev_sign;
  logic [1:0]               cur_sign;
  logic [1:0]               held_signal;
  logic [1:0]               held_next;
  logic [DAYS_W-1:0]        days_counter;
  logic [DAYS_W-1:0]        days_next;
  logic                     cross_next;
  logic                     now_ge;
  logic                     now_le;
  logic                     was_ge;
  logic                     was_le;

  // Result holding and divider.
  logic [1:0]        res_signal;
  logic              res_cross;
  logic [DAYS_W-1:0] res_days;
  logic [CONF_W-1:0] res_conf;
  logic              div_done;
  logic [CONF_W-1:0] quotient;
  logic              out_free;

  assign clear = cfg_wr && ((cfg_index == REG_SHORT_WINDOW) || (cfg_index == REG_LONG_WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= SHORT_WINDOW_RST;
      long_window  <= LONG_WINDOW_RST;
    end else if (cfg_wr) begin
      if (cfg_index == REG_SHORT_WINDOW) begin
        short_window <= cfg_data;
      end
      if (cfg_index == REG_LONG_WINDOW) begin
        long_window <= cfg_data;
      end
    end
  end

  always_comb begin
    sw_ext = CMP_W'(short_window);
    lw_ext = CMP_W'(long_window);
    if (short_window == '0) begin
      s_c = WIN_W'(1);
    end else if (sw_ext > CMP_W'(MAX_WINDOW)) begin
      s_c = WIN_W'(MAX_WINDOW);
    end else begin
      s_c = WIN_W'(sw_ext);
    end
    if (long_window == '0) begin
      l_c = WIN_W'(1);
    end else if (lw_ext > CMP_W'(MAX_WINDOW)) begin
      l_c = WIN_W'(MAX_WINDOW);
    end else begin
      l_c = WIN_W'(lw_ext);
    end
    win_s = (s_c > l_c) ? l_c : s_c;
    win_l = (s_c > l_c) ? s_c : l_c;
  end

  always_comb begin
    sum_s   = AW'(wp) + AW'(MAX_WINDOW) - AW'(win_s);
    sum_l   = AW'(wp) + AW'(MAX_WINDOW) - AW'(win_l);
    addr_s  = (sum_s >= AW'(MAX_WINDOW)) ? PTR_W'(sum_s - AW'(MAX_WINDOW)) : PTR_W'(sum_s);
    addr_l  = (sum_l >= AW'(MAX_WINDOW)) ? PTR_W'(sum_l - AW'(MAX_WINDOW)) : PTR_W'(sum_l);
    rd_addr = cmd.rd_long ? addr_l : addr_s;
    wp_next = (wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
  end

  always_ff @(posedge clk) begin
    rdata <= hist_mem[rd_addr];
    if (cmd.update) begin
      hist_mem[wp] <= price_r;
    end
  end

  always_comb begin
    drop_s            = (samples_seen >= win_s) ? SUM_W'(old_s) : '0;
    drop_l            = (samples_seen >= win_l) ? SUM_W'(rdata) : '0;
    short_sum_next    = short_sum - drop_s + SUM_W'(price_r);
    long_sum_next     = long_sum - drop_l + SUM_W'(price_r);
    samples_seen_next = (samples_seen < WIN_W'(MAX_WINDOW)) ? samples_seen + 1'b1
                                                            : samples_seen;
    warm              = (samples_seen_next < win_l);
  end

  always_comb begin
    mul_a   = cmd.mul_rhs ? long_sum : short_sum;
    mul_b   = cmd.mul_rhs ? $signed({1'b0, win_s}) : $signed({1'b0, win_l});
    mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    if (lhs > rhs) begin
      cur_sign = SGN_POS;
    end else if (lhs < rhs) begin
      cur_sign = SGN_NEG;
    end else begin
      cur_sign = SGN_ZERO;
    end
    now_ge     = (cur_sign != SGN_NEG);
    now_le     = (cur_sign != SGN_POS);
    was_ge     = (prev_sign != SGN_NEG);
    was_le     = (prev_sign != SGN_POS);
    held_next  = held_signal;
    cross_next = 1'b0;
    days_next  = '0;
    if (prev_sign != SGN_NONE) begin
      priority if (now_ge && was_le) begin
        held_next  = SIG_BUY;
        cross_next = 1'b1;
      end else if (now_le && was_ge) begin
        held_next  = SIG_SELL;
        cross_next = 1'b1;
      end
      if (cross_next) begin
        days_next = '0;
      end else if (days_counter < DAYS_MAX) begin
        days_next = days_counter + 1'b1;
      end else begin
        days_next = days_counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wp           <= '0;
      samples_seen <= '0;
      short_sum    <= '0;
      long_sum     <= '0;
      prev_sign    <= SGN_NONE;
      held_signal  <= SIG_NOTREND;
      days_counter <= '0;
    end else begin
      if (cmd.update) begin
        wp           <= wp_next;
        samples_seen <= samples_seen_next;
        short_sum    <= short_sum_next;
        long_sum     <= long_sum_next;
      end
      if (cmd.compare) begin
        prev_sign    <= cur_sign;
        held_signal  <= held_next;
        days_counter <= days_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price_r <= price;
    end
    if (cmd.capture_short) begin
      old_s <= rdata;
    end
    if (cmd.mul_lhs) begin
      lhs <= mul_out;
    end
    if (cmd.mul_rhs) begin
      rhs <= mul_out;
    end
    if (cmd.update && warm) begin
      res_signal <= SIG_WARMUP;
      res_cross  <= 1'b0;
      res_days   <= '0;
      res_conf   <= CONF_BASE;
    end
    if (cmd.compare) begin
      res_signal <= held_next;
      res_cross  <= cross_next;
      res_days   <= days_next;
    end
    if (cmd.take_quot) begin
      res_conf <= CONF_BASE + quotient;
    end
  end

  macs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.compare),
    .divisor  (DIV_W'(days_next) + DIV_W'(2)),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !result_valid || !result_stall;
  assign status   = '{warm: warm, div_done: div_done, out_free: out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      signal                <= res_signal;
      crossover             <= res_cross;
      days_since            <= res_days;
      confidence_hundredths <= res_conf;
    end
  end

endmodule

// File: sv/macs_checker.sv
// ----------------------------------------------------------------------------
// Moving average crossover checker
// Port-level properties of the crossover core, attached by a bind statement.
// ----------------------------------------------------------------------------
module macs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        sample_valid,
  input logic                        sample_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [1:0]                  signal,
  input logic                        crossover,
  input logic [macs_pkg::DAYS_W-1:0] days_since,
  input logic [macs_pkg::CONF_W-1:0] confidence_hundredths
);
  import macs_pkg::*;

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("Sample taken while previous transaction still in work.");

  a_warmup_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (signal == SIG_WARMUP)) |->
      (!crossover && (days_since == '0) && (confidence_hundredths == CONF_BASE)))
    else $error("Warm-up result carries wrong fields.");

  a_crossover_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && crossover) |->
      ((days_since == '0) && (confidence_hundredths == CONF_NUM) &&
       ((signal == SIG_BUY) || (signal == SIG_SELL))))
    else $error("Crossover result carries wrong fields.");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(signal) && $stable(crossover) &&
       $stable(days_since) && $stable(confidence_hundredths)))
    else $error("Stalled result changed.");

endmodule

bind moving_average_crossover_signal_core macs_checker u_macs_checker (.*);
